### hdl/lfsu_pkg.sv
package lfsu_pkg;

  // Configuration port geometry and register indexes
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgLearnRate = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRegWeight = 2'd1;

  // Register values after reset (eta and lambda, unsigned Q0.16)
  localparam logic [CfgDataW-1:0] LearnRateRst = 16'd655;
  localparam logic [CfgDataW-1:0] RegWeightRst = 16'd3277;

  // Queue depths between front and back, and in front of the result ports
  localparam int unsigned CmdQDepth = 2;
  localparam int unsigned OutQDepth = 8;
  localparam int unsigned OutCntW   = $clog2(OutQDepth + 1);

  typedef enum logic [2:0] {
    F_LOAD,
    F_ACC,
    F_ERR,
    F_GAIN,
    F_ISSUE,
    F_WAIT
  } front_state_e;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_e;

  // Update coefficients for one vector: gain = eta*error (Q16.16), f1 = 1 - eta*lambda (Q1.32)
  typedef struct packed {
    logic [31:0] gain;
    logic [32:0] f1;
  } cmd_t;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } result_t;

  // Clamp a 65-bit two's complement value to signed 32 bits
  function automatic logic [31:0] sat32(input logic [64:0] x);
    if ((&x[64:31]) || (~|x[64:31])) begin
      return x[31:0];
    end else if (x[64]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7fff_ffff;
    end
  endfunction

endpackage

### hdl/latent_factor_sgd_update_core.sv
// One SGD step of matrix factorization in signed Q16.16. Push the user and item factor
// elements of a vector one pair per cycle while full is low, the rating riding with the
// pair marked last_elem; pairs beyond RANK are dropped but a late last pair still closes
// the vector. After the last pair is accepted the front forms the error and coefficients,
// the back reads the factor store and the first updated user element reaches the result
// ports; the rest follow one per cycle while pop keeps up, the final one flagged by
// last_out_o. Input is held off (full high) from the last pair until the last factor has
// been read back from the factor store; a backed-up result queue stalls the read-back and
// holds it off longer. learn_rate (index 0) and reg_weight (index 1) are unsigned Q0.16;
// the user must write them only while the block is idle; the block does not enforce it.
module latent_factor_sgd_update_core import lfsu_pkg::*; #(
  parameter int unsigned RANK = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // items
  input  logic                push,
  output logic                full,
  input  logic signed [31:0]  user_elem_i,
  input  logic signed [31:0]  item_elem_i,
  input  logic signed [31:0]  rating_value_i,
  input  logic                last_elem_i,
  // results
  output logic                empty,
  input  logic                pop,
  output logic signed [31:0]  new_user_elem_o,
  output logic                last_out_o
);

  localparam int unsigned AddrW = (RANK > 1) ? $clog2(RANK) : 1;
  localparam int unsigned CntW  = $clog2(RANK + 1);
  localparam int unsigned CmdW  = CntW + $bits(cmd_t);

  logic               wr_en;
  logic [AddrW-1:0]   wr_addr;
  logic [31:0]        wr_user, wr_item;
  logic               cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic [CmdW-1:0]    cmd_wdata, cmd_rdata;
  logic               back_busy;
  logic               out_push;
  result_t            out_wdata, out_head;
  logic [OutCntW-1:0] out_cnt;

  lfsu_front #(.RANK(RANK)) u_front (
    .clk_i,
    .rst_ni,
    .push_i         (push),
    .full_o         (full),
    .user_elem_i,
    .item_elem_i,
    .rating_value_i,
    .last_elem_i,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_user_o      (wr_user),
    .wr_item_o      (wr_item),
    .cmd_push_o     (cmd_push),
    .cmd_data_o     (cmd_wdata),
    .cmd_full_i     (cmd_full),
    .cmd_empty_i    (cmd_empty),
    .back_busy_i    (back_busy)
  );

  // Coefficient queue between front and back
  lfsu_fifo #(.WIDTH(CmdW), .DEPTH(CmdQDepth)) u_cmd_q (
    .clk_i,
    .rst_ni,
    .push_i  (cmd_push),
    .wdata_i (cmd_wdata),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .full_o  (cmd_full),
    .empty_o (cmd_empty),
    .count_o ()
  );

  lfsu_back #(.RANK(RANK)) u_back (
    .clk_i,
    .rst_ni,
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_user_i   (wr_user),
    .wr_item_i   (wr_item),
    .cmd_empty_i (cmd_empty),
    .cmd_data_i  (cmd_rdata),
    .cmd_pop_o   (cmd_pop),
    .busy_o      (back_busy),
    .out_cnt_i   (out_cnt),
    .out_push_o  (out_push),
    .out_data_o  (out_wdata)
  );

  // Result queue in front of the output ports
  lfsu_fifo #(.WIDTH($bits(result_t)), .DEPTH(OutQDepth)) u_out_q (
    .clk_i,
    .rst_ni,
    .push_i  (out_push),
    .wdata_i (out_wdata),
    .pop_i   (pop),
    .rdata_o (out_head),
    .full_o  (),
    .empty_o (empty),
    .count_o (out_cnt)
  );

  assign new_user_elem_o = $signed(out_head.value);
  assign last_out_o      = out_head.last;

endmodule

### hdl/lfsu_fifo.sv
module lfsu_fifo import lfsu_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o,
  output logic [CntW-1:0]  count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming transaction
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### hdl/lfsu_front.sv
module lfsu_front import lfsu_pkg::*; #(
  parameter int unsigned RANK = 16,
  localparam int unsigned AddrW = (RANK > 1) ? $clog2(RANK) : 1,
  localparam int unsigned CntW  = $clog2(RANK + 1),
  localparam int unsigned CmdW  = CntW + $bits(cmd_t)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item side
  input  logic                push_i,
  output logic                full_o,
  input  logic signed [31:0]  user_elem_i,
  input  logic signed [31:0]  item_elem_i,
  input  logic signed [31:0]  rating_value_i,
  input  logic                last_elem_i,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // factor store write port
  output logic                wr_en_o,
  output logic [AddrW-1:0]    wr_addr_o,
  output logic [31:0]         wr_user_o,
  output logic [31:0]         wr_item_o,
  // command queue
  output logic                cmd_push_o,
  output logic [CmdW-1:0]     cmd_data_o,
  input  logic                cmd_full_i,
  input  logic                cmd_empty_i,
  input  logic                back_busy_i
);

  front_state_e       state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic signed [63:0] prod_q;
  logic               prod_vld_q;
  logic signed [63:0] acc_q, acc_d;
  logic [31:0]        rating_q;
  logic [31:0]        err_q;
  logic [31:0]        wt_prod_q;
  cmd_t               cmd_q;
  logic [CfgDataW-1:0] learn_rate_q, reg_weight_q;

  logic               accept, store;
  logic [64:0]        acc_sum;
  logic [64:0]        err_diff;
  logic signed [63:0] err_sat;
  logic signed [63:0] err_shift;
  logic signed [48:0] gain_prod;

  // Clamp a 65-bit two's complement value to signed 64 bits
  function automatic logic [63:0] sat64(input logic [64:0] x);
    if (x[64] == x[63]) begin
      return x[63:0];
    end else if (x[64]) begin
      return 64'h8000_0000_0000_0000;
    end else begin
      return 64'h7fff_ffff_ffff_ffff;
    end
  endfunction

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_LOAD:  if (accept && last_elem_i) state_d = F_ACC;
      F_ACC:   state_d = F_ERR;
      F_ERR:   state_d = F_GAIN;
      F_GAIN:  state_d = F_ISSUE;
      F_ISSUE: if (!cmd_full_i) state_d = F_WAIT;
      F_WAIT:  if (!back_busy_i && cmd_empty_i) state_d = F_LOAD;
      default: state_d = F_LOAD;
    endcase
  end

  // State outputs
  always_comb begin
    full_o     = 1'b1;
    cmd_push_o = 1'b0;
    case (state_q)
      F_LOAD:  full_o = 1'b0;
      F_ISSUE: cmd_push_o = !cmd_full_i;
      default: ;
    endcase
  end

  assign accept = push_i && !full_o;
  // Drop pairs beyond the vector length
  assign store  = accept && (cnt_q < CntW'(RANK));

  assign wr_en_o    = store;
  assign wr_addr_o  = cnt_q[AddrW-1:0];
  assign wr_user_o  = user_elem_i;
  assign wr_item_o  = item_elem_i;
  assign cmd_data_o = {cnt_q, cmd_q};

  // Saturating dot product accumulation
  assign acc_sum = {acc_q[63], acc_q} + {prod_q[63], prod_q};

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (cmd_push_o) begin
      acc_d = '0;
      cnt_d = '0;
    end else begin
      if (prod_vld_q) acc_d = $signed(sat64(acc_sum));
      if (store)      cnt_d = cnt_q + 1'b1;
    end
  end

  // Error: rating minus dot product, back to Q16.16
  assign err_diff  = {{17{rating_q[31]}}, rating_q, 16'h0000} - {acc_q[63], acc_q};
  assign err_sat   = $signed(sat64(err_diff));
  assign err_shift = err_sat >>> 16;

  // Gain: eta * error, still Q16.16 after the shift; always fits 32 bits
  assign gain_prod = $signed({{33{1'b0}}, learn_rate_q}) * $signed({{17{err_q[31]}}, err_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_rate_q <= LearnRateRst;
      reg_weight_q <= RegWeightRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLearnRate: learn_rate_q <= cfg_data_i;
        CfgRegWeight: reg_weight_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_LOAD;
      cnt_q      <= '0;
      acc_q      <= '0;
      prod_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      acc_q      <= acc_d;
      prod_vld_q <= store;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (store) begin
      prod_q <= $signed({{32{user_elem_i[31]}}, user_elem_i})
              * $signed({{32{item_elem_i[31]}}, item_elem_i});
    end
    if (accept && last_elem_i) begin
      rating_q <= rating_value_i;
    end
    if (state_q == F_ERR) begin
      err_q     <= sat32({err_shift[63], err_shift});
      wt_prod_q <= {16'h0000, learn_rate_q} * {16'h0000, reg_weight_q};
    end
    if (state_q == F_GAIN) begin
      cmd_q.gain <= gain_prod[47:16];
      cmd_q.f1   <= 33'h1_0000_0000 - {1'b0, wt_prod_q};
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(RANK))
    else $error("element count beyond rank");

  a_issue_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_ISSUE) |-> (cnt_q != '0))
    else $error("update issued for an empty vector");

  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == F_LOAD) && (cnt_q == '0) && !prod_vld_q) |-> (acc_q == '0))
    else $error("dot product not cleared at vector start");

endmodule

### hdl/lfsu_back.sv
module lfsu_back import lfsu_pkg::*; #(
  parameter int unsigned RANK = 16,
  localparam int unsigned AddrW = (RANK > 1) ? $clog2(RANK) : 1,
  localparam int unsigned CntW  = $clog2(RANK + 1),
  localparam int unsigned CmdW  = CntW + $bits(cmd_t)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // factor store write port
  input  logic               wr_en_i,
  input  logic [AddrW-1:0]   wr_addr_i,
  input  logic [31:0]        wr_user_i,
  input  logic [31:0]        wr_item_i,
  // command queue
  input  logic               cmd_empty_i,
  input  logic [CmdW-1:0]    cmd_data_i,
  output logic               cmd_pop_o,
  output logic               busy_o,
  // result queue
  input  logic [OutCntW-1:0] out_cnt_i,
  output logic               out_push_o,
  output result_t            out_data_o
);

  back_state_e        state_q, state_d;
  logic [CntW-1:0]    n_q, idx_q;
  cmd_t               coef_q;
  logic [31:0]        user_mem [RANK];
  logic [31:0]        item_mem [RANK];
  logic               s1_vld_q, s1_last_q, s2_vld_q, s2_last_q;
  logic [31:0]        rd_user_q, rd_item_q;
  logic signed [63:0] p1_q, p2_q;

  logic               start, issue, idx_last, credit;
  logic [OutCntW:0]   pending;
  logic signed [63:0] t1;
  logic signed [64:0] upd_sum;
  logic signed [64:0] upd_shift;

  // Results in flight plus queued must leave room in the result queue
  assign pending  = {1'b0, out_cnt_i} + (OutCntW + 1)'(s1_vld_q) + (OutCntW + 1)'(s2_vld_q);
  assign credit   = (pending < (OutCntW + 1)'(OutQDepth));
  assign idx_last = (idx_q == (n_q - 1'b1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (!cmd_empty_i) state_d = B_RUN;
      B_RUN:   if (credit && idx_last) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    start  = 1'b0;
    issue  = 1'b0;
    busy_o = 1'b0;
    case (state_q)
      B_IDLE:  start = !cmd_empty_i;
      B_RUN: begin
        issue  = credit;
        busy_o = 1'b1;
      end
      default: ;
    endcase
  end

  assign cmd_pop_o = start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      idx_q    <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      if (start) begin
        idx_q <= '0;
      end else if (issue) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // Latch coefficients of the accepted command
  always_ff @(posedge clk_i) begin
    if (start) begin
      {n_q, coef_q} <= cmd_data_i;
    end
  end

  // Factor store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      user_mem[wr_addr_i] <= wr_user_i;
      item_mem[wr_addr_i] <= wr_item_i;
    end
    if (issue) begin
      rd_user_q <= user_mem[idx_q[AddrW-1:0]];
      rd_item_q <= item_mem[idx_q[AddrW-1:0]];
      s1_last_q <= idx_last;
    end
  end

  // Products u*f1 and gain*m; both fit 64 bits
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      p1_q      <= $signed({{32{rd_user_q[31]}}, rd_user_q}) * $signed({31'h0, coef_q.f1});
      p2_q      <= $signed({{32{coef_q.gain[31]}}, coef_q.gain})
                 * $signed({{32{rd_item_q[31]}}, rd_item_q});
      s2_last_q <= s1_last_q;
    end
  end

  // Combine, rescale to Q16.16 and saturate
  assign t1        = p1_q >>> 16;
  assign upd_sum   = $signed({t1[63], t1}) + $signed({p2_q[63], p2_q});
  assign upd_shift = upd_sum >>> 16;

  assign out_push_o       = s2_vld_q;
  assign out_data_o.value = sat32(upd_shift);
  assign out_data_o.last  = s2_last_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> (out_cnt_i < OutCntW'(OutQDepth)))
    else $error("result pushed into a full queue");

  a_store_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> (state_q == B_IDLE))
    else $error("factor store written during an update");

endmodule
